// ===== sv/usb_command_frame_builder_defines.svh =====
// assertion macros shared by the frame builder checker
// no dependencies; take in with `include before any use
`ifndef USB_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define USB_COMMAND_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define UCFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// next-cycle implication
`define UCFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

// ===== sv/ucfb_pkg.sv =====
// shared types and constants of the command frame builder
// no dependencies; used by ucfb_front, ucfb_queue, ucfb_back and the top level
package ucfb_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [7:0] LEN_OVERHEAD = 8'd5;

	// output byte sequencer steps
	typedef enum logic [2:0] {
		ST_LEN,
		ST_CMD_HI,
		ST_CMD_LO,
		ST_SEQ,
		ST_DATA,
		ST_CK_HI,
		ST_CK_LO
	} step_t;

	// one classified input beat, as queued between front and back
	typedef struct packed {
		logic        first;
		logic        hdr_only;
		logic        last;
		logic [15:0] cmd;
		logic [7:0]  len;
		logic [7:0]  seq;
		logic [7:0]  data;
	} entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/ucfb_in_if.sv =====
// input channel of the frame builder: one payload byte per beat
// depends on nothing but the handshake convention valid/ready
interface ucfb_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] command_code;
	logic [7:0]  payload_len;
	logic [7:0]  data_byte;

	modport source (output valid, command_code, payload_len, data_byte, input ready);
	modport sink (input valid, command_code, payload_len, data_byte, output ready);
endinterface

// ===== sv/ucfb_out_if.sv =====
// output channel of the frame builder: one frame byte per beat
// depends on nothing but the handshake convention valid/ready
interface ucfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

// ===== sv/ucfb_front.sv =====
// front end: accepts input beats, tracks frame position and sequence count
// depends on ucfb_pkg and ucfb_in_if
module ucfb_front (
	input  logic             clk,
	input  logic             arst_n,
	ucfb_in_if.sink          cmd,
	input  ucfb_pkg::q_stat_t q_stat,
	output logic             push,
	output ucfb_pkg::entry_t push_entry
);

	logic       inside_q;
	logic [7:0] rem_q;
	logic [7:0] seq_q;
	logic       accept;

	// accept whenever the queue has room
	assign cmd.ready = !q_stat.full;
	assign accept    = cmd.valid && cmd.ready;
	assign push      = accept;

	// classify the beat
	always_comb begin
		push_entry.first    = !inside_q;
		push_entry.cmd      = cmd.command_code;
		push_entry.len      = cmd.payload_len;
		push_entry.seq      = seq_q;
		push_entry.data     = cmd.data_byte;
		if (!inside_q) begin
			push_entry.hdr_only = (cmd.payload_len == 8'd0);
			push_entry.last     = (cmd.payload_len == 8'd1);
		end else begin
			push_entry.hdr_only = 1'b0;
			push_entry.last     = (rem_q == 8'd1);
		end
	end

	// frame position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			rem_q    <= 8'd0;
			seq_q    <= 8'd0;
		end else if (accept) begin
			if (!inside_q) begin
				seq_q <= seq_q + 8'd1;
				if (cmd.payload_len > 8'd1) begin
					inside_q <= 1'b1;
				end
				rem_q <= cmd.payload_len - 8'd1;
			end else begin
				rem_q <= rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					inside_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/ucfb_queue.sv =====
// short queue of classified beats between front and back
// depends on ucfb_pkg
module ucfb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ucfb_pkg::entry_t  push_entry,
	input  logic              pop,
	output ucfb_pkg::entry_t  head,
	output ucfb_pkg::q_stat_t q_stat
);

	ucfb_pkg::entry_t            mem_q [ucfb_pkg::QDEPTH];
	logic [ucfb_pkg::QAW-1:0]    wr_ptr_q;
	logic [ucfb_pkg::QAW-1:0]    rd_ptr_q;
	logic [ucfb_pkg::QAW:0]      count_q;

	assign q_stat.full  = (count_q == (ucfb_pkg::QAW+1)'(ucfb_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ucfb_back.sv =====
// back end: expands queued beats into frame bytes, keeps the checksum
// depends on ucfb_pkg and ucfb_out_if
module ucfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ucfb_pkg::entry_t  head,
	input  ucfb_pkg::q_stat_t q_stat,
	output logic              pop,
	ucfb_out_if.source        frame
);

	logic                  start_q;
	ucfb_pkg::step_t       step_q;
	logic [15:0]           acc_q;
	logic                  hb_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	ucfb_pkg::step_t       cur_step;
	ucfb_pkg::step_t       next_step;
	logic                  done;
	logic                  load;
	logic [7:0]            byte_val;
	logic                  last_val;
	logic [15:0]           ck;

	assign load     = !q_stat.empty && (!out_valid_q || frame.ready);
	assign pop      = load && done;
	assign cur_step = start_q ? (head.first ? ucfb_pkg::ST_LEN : ucfb_pkg::ST_DATA) : step_q;
	assign ck       = ~acc_q;

	// next step of the sequencer
	always_comb begin
		next_step = cur_step;
		done      = 1'b0;
		case (cur_step)
			ucfb_pkg::ST_LEN:    next_step = ucfb_pkg::ST_CMD_HI;
			ucfb_pkg::ST_CMD_HI: next_step = ucfb_pkg::ST_CMD_LO;
			ucfb_pkg::ST_CMD_LO: next_step = ucfb_pkg::ST_SEQ;
			ucfb_pkg::ST_SEQ:
				next_step = head.hdr_only ? ucfb_pkg::ST_CK_HI : ucfb_pkg::ST_DATA;
			ucfb_pkg::ST_DATA: begin
				if (head.last) begin
					next_step = ucfb_pkg::ST_CK_HI;
				end else begin
					done = 1'b1;
				end
			end
			ucfb_pkg::ST_CK_HI:  next_step = ucfb_pkg::ST_CK_LO;
			ucfb_pkg::ST_CK_LO:  done = 1'b1;
			default:             done = 1'b1;
		endcase
	end

	// byte shown for the current step
	always_comb begin
		byte_val = head.data;
		last_val = 1'b0;
		case (cur_step)
			ucfb_pkg::ST_LEN:    byte_val = head.len + ucfb_pkg::LEN_OVERHEAD;
			ucfb_pkg::ST_CMD_HI: byte_val = head.cmd[15:8];
			ucfb_pkg::ST_CMD_LO: byte_val = head.cmd[7:0];
			ucfb_pkg::ST_SEQ:    byte_val = head.seq;
			ucfb_pkg::ST_DATA:   byte_val = head.data;
			ucfb_pkg::ST_CK_HI:  byte_val = ck[15:8];
			ucfb_pkg::ST_CK_LO: begin
				byte_val = ck[7:0];
				last_val = 1'b1;
			end
			default:             byte_val = head.data;
		endcase
	end

	// sequencer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			step_q  <= ucfb_pkg::ST_LEN;
		end else if (load) begin
			start_q <= done;
			step_q  <= next_step;
		end
	end

	// running word sum; header words seed it at the length byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 16'd0;
			hb_q  <= 1'b0;
		end else if (load) begin
			if (cur_step == ucfb_pkg::ST_LEN) begin
				acc_q <= head.cmd + {head.seq, 8'h00};
				hb_q  <= 1'b0;
			end else if (cur_step == ucfb_pkg::ST_DATA) begin
				acc_q <= acc_q + (hb_q ? {head.data, 8'h00} : {8'h00, head.data});
				hb_q  <= !hb_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_val;
			out_last_q <= last_val;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_last = out_last_q;

endmodule

// ===== sv/usb_command_frame_builder.sv =====
// command frame builder, top level
// channels: cmd (sink) takes one payload byte per beat; the first beat of a
//   frame also carries command_code and payload_len (0 = header-only frame)
// frame (source) gives the frame bytes LEN, CMD_HI, CMD_LO, SEQ, payload,
//   checksum high, checksum low; frame_last marks the checksum low byte
// throughput: one frame byte per cycle while the queue holds beats and frame.ready is high;
//   a payload-only beat gives one byte, the first beat of a frame four more for the header,
//   the last beat two more for the checksum; the back-end byte sequencer sets this rate
// path: an accepted beat is written into the queue, and its first byte is then registered
//   in the output register when the back end is idle and the output is free
// cmd.ready follows the four-entry queue between front and back, so input
//   beats keep coming in while the back end works or the receiver stalls
// on a frame stall the output byte holds and the queue fills, then
//   cmd.ready drops
// reset clears the sequence count, frame position, queue and output valid
// depends on ucfb_pkg, the interfaces, ucfb_front, ucfb_queue, ucfb_back
module usb_command_frame_builder (
	input  logic      clk,
	input  logic      arst_n,
	ucfb_in_if.sink   cmd,
	ucfb_out_if.source frame
);

	logic              push;
	logic              pop;
	ucfb_pkg::entry_t  push_entry;
	ucfb_pkg::entry_t  head;
	ucfb_pkg::q_stat_t q_stat;

	ucfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	ucfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	ucfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.frame  (frame)
	);

endmodule

// ===== sv/ucfb_checker.sv =====
// port-level checks of the frame builder, bound to the top level
// depends on usb_command_frame_builder_defines.svh
`include "usb_command_frame_builder_defines.svh"

module ucfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	logic prev_last_q;

	// last flag of the previous delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			prev_last_q <= out_last;
		end
	end

	// a stalled output beat holds
	`UCFB_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

	// a frame is at least six bytes, so two ending beats never follow each other
	`UCFB_ASSERT_IMP(a_no_double_last, clk, arst_n, out_valid && out_last, !prev_last_q)

	// an accepted beat is always followed by output valid once it has passed the queue and output register
	`UCFB_ASSERT_IMP(a_accept_drives_out, clk, arst_n, in_valid && in_ready, ##2 out_valid)

endmodule

bind usb_command_frame_builder ucfb_checker u_ucfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_byte  (frame.frame_byte),
	.out_last  (frame.frame_last)
);
